/* design/mgtu_pkg.sv */
// ----------------------------------------------------------------------------
// mgtu_pkg
// Shared types, codes and constants of the message pin, timer and interrupt
// unit.
// ----------------------------------------------------------------------------
package mgtu_pkg;

   // Sizing of the unit
   localparam int NUM_TIMERS = 10;
   localparam int NUM_PINS   = 32;
   localparam int TICK_US    = 50;

   // Field widths
   localparam int OPCODE_W = 3;
   localparam int MSG_W    = 8;
   localparam int CMD_W    = 3;
   localparam int ARG_W    = 5;
   localparam int TIDX_W   = 4;
   localparam int US_W     = 32;
   localparam int PIN_W    = 5;
   localparam int STATUS_W = 2;
   localparam int PINS_W   = 32;
   localparam int TICK_W   = 27;

   localparam logic [TICK_W-1:0] TICK_MAX = '1;

   // Reciprocal for period_us / TICK_US: q_est = (x * DIV_MAGIC) >> DIV_SHIFT
   // is the quotient or one below it; one compare and increment corrects it.
   localparam int DIV_SHIFT = US_W + $clog2(TICK_US);
   localparam int PROD_W    = US_W + DIV_SHIFT;
   localparam logic [PROD_W-1:0] DIV_MAGIC =
      PROD_W'((PROD_W'(1) << DIV_SHIFT) / TICK_US);
   localparam logic [US_W-1:0] TICK_US_W = US_W'(TICK_US);

   // Outgoing message bytes
   localparam logic [MSG_W-1:0] TX_DRIVE_BASE = 8'h00;
   localparam logic [MSG_W-1:0] TX_DIR_BASE   = 8'h40;
   localparam logic [MSG_W-1:0] TX_LEVEL_BIT  = 8'h20;
   localparam logic [MSG_W-1:0] TX_END_IRQ    = 8'h80;

   typedef enum logic [OPCODE_W-1:0] {
      OP_RECEIVE   = 3'd0,
      OP_START     = 3'd1,
      OP_CHECK     = 3'd2,
      OP_DRIVE     = 3'd3,
      OP_DIRECTION = 3'd4,
      OP_END_IRQ   = 3'd5
   } opcode_type;

   typedef enum logic [CMD_W-1:0] {
      CMD_PIN_LOW  = 3'd0,
      CMD_PIN_HIGH = 3'd1,
      CMD_TICK     = 3'd2,
      CMD_IRQ      = 3'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_BAD_CMD   = 2'd1,
      ST_IRQ_BUSY  = 2'd2,
      ST_BAD_TIMER = 2'd3
   } status_type;

   typedef struct packed {
      logic [OPCODE_W-1:0] opcode;
      logic [MSG_W-1:0]    msg_byte;
      logic [TIDX_W-1:0]   timer_index;
      logic [US_W-1:0]     period_us;
      logic [PIN_W-1:0]    pin_number;
      logic                pin_level;
      logic                output_mode;
   } req_item_type;

   typedef struct packed {
      status_type          status;
      logic                tx_valid;
      logic [MSG_W-1:0]    tx_byte;
      logic                timer_fired;
      logic [PINS_W-1:0]   pin_states;
      logic                irq_active;
      logic [ARG_W-1:0]    irq_number;
   } rsp_item_type;

endpackage

/* design/mgtu_tick_div.sv */
// ----------------------------------------------------------------------------
// mgtu_tick_div
// Converts a period in microseconds to timer ticks: registered reciprocal
// multiply, then a one-step correction and saturation to the tick width.
// ----------------------------------------------------------------------------
module mgtu_tick_div (
   input  logic                             clock,
   input  logic                             enable,
   input  logic [mgtu_pkg::US_W-1:0]        period_us,
   output logic [mgtu_pkg::TICK_W-1:0]      ticks
);

   logic [mgtu_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic [mgtu_pkg::US_W-1:0]   num_ff;
   logic [mgtu_pkg::US_W-1:0]   q_est;
   logic [mgtu_pkg::US_W-1:0]   q_fix;
   logic [mgtu_pkg::US_W-1:0]   rem;

   // Multiply by the reciprocal
   assign prod_in = mgtu_pkg::PROD_W'(period_us) * mgtu_pkg::DIV_MAGIC;

   // Hold the product alongside its numerator
   always_ff @(posedge clock) begin
      if (enable) begin
         prod_ff <= prod_in;
         num_ff  <= period_us;
      end
   end

   // Correct the estimate by one where the remainder reaches the divisor
   always_comb begin
      q_est = prod_ff[mgtu_pkg::DIV_SHIFT +: mgtu_pkg::US_W];
      rem   = num_ff - mgtu_pkg::US_W'(q_est * mgtu_pkg::TICK_US_W);
      q_fix = q_est + mgtu_pkg::US_W'(rem >= mgtu_pkg::TICK_US_W);
      if (q_fix > mgtu_pkg::US_W'(mgtu_pkg::TICK_MAX)) begin
         ticks = mgtu_pkg::TICK_MAX;
      end else begin
         ticks = q_fix[mgtu_pkg::TICK_W-1:0];
      end
   end

endmodule

/* design/mgtu_core.sv */
// ----------------------------------------------------------------------------
// mgtu_core
// Holds pins, timers and the interrupt latch; applies one item per commit
// and forms its result from the updated state.
// ----------------------------------------------------------------------------
module mgtu_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           commit,
   input  mgtu_pkg::req_item_type         item,
   input  logic [mgtu_pkg::TICK_W-1:0]    ticks,
   output mgtu_pkg::rsp_item_type         result
);

   localparam int NT = mgtu_pkg::NUM_TIMERS;

   logic [mgtu_pkg::PINS_W-1:0] pin_bits_ff, pin_bits_in;
   logic [mgtu_pkg::TICK_W-1:0] period_ff [NT];
   logic [mgtu_pkg::TICK_W-1:0] period_in [NT];
   logic [mgtu_pkg::TICK_W-1:0] count_ff  [NT];
   logic [mgtu_pkg::TICK_W-1:0] count_in  [NT];
   logic [NT-1:0]               fired_ff, fired_in;
   logic                        irq_pending_ff, irq_pending_in;
   logic [mgtu_pkg::ARG_W-1:0]  irq_id_ff, irq_id_in;

   logic [NT-1:0]               timer_hit;
   logic                        timer_ok;
   logic                        do_tick, do_start, do_clear;
   logic                        pin_wr;
   logic [mgtu_pkg::PIN_W-1:0]  pin_num;
   logic                        pin_lvl;
   logic [mgtu_pkg::PINS_W-1:0] pin_mask;
   logic [mgtu_pkg::CMD_W-1:0]  cmd;
   logic [mgtu_pkg::ARG_W-1:0]  arg;

   // Timer lane select and range check
   assign timer_ok = {1'b0, item.timer_index} < (mgtu_pkg::TIDX_W + 1)'(NT);
   for (genvar i = 0; i < NT; i++) begin : g_hit
      assign timer_hit[i] = item.timer_index == mgtu_pkg::TIDX_W'(i);
   end

   assign cmd = item.msg_byte[mgtu_pkg::MSG_W-1 -: mgtu_pkg::CMD_W];
   assign arg = item.msg_byte[mgtu_pkg::ARG_W-1:0];

   // Decode the item and form the result
   always_comb begin
      result          = '0;
      result.status   = mgtu_pkg::ST_OK;
      do_tick         = 1'b0;
      do_start        = 1'b0;
      do_clear        = 1'b0;
      pin_wr          = 1'b0;
      pin_num         = item.pin_number;
      pin_lvl         = item.pin_level;
      irq_pending_in  = irq_pending_ff;
      irq_id_in       = irq_id_ff;
      case (item.opcode)
         mgtu_pkg::OP_RECEIVE: begin
            case (cmd)
               mgtu_pkg::CMD_PIN_LOW: begin
                  pin_wr  = 1'b1;
                  pin_num = arg;
                  pin_lvl = 1'b0;
               end
               mgtu_pkg::CMD_PIN_HIGH: begin
                  pin_wr  = 1'b1;
                  pin_num = arg;
                  pin_lvl = 1'b1;
               end
               mgtu_pkg::CMD_TICK: begin
                  do_tick = 1'b1;
               end
               mgtu_pkg::CMD_IRQ: begin
                  if (irq_pending_ff) begin
                     result.status = mgtu_pkg::ST_IRQ_BUSY;
                  end else begin
                     irq_pending_in = 1'b1;
                     irq_id_in      = arg;
                  end
               end
               default: begin
                  result.status = mgtu_pkg::ST_BAD_CMD;
               end
            endcase
         end
         mgtu_pkg::OP_START: begin
            if (timer_ok) begin
               do_start = 1'b1;
            end else begin
               result.status = mgtu_pkg::ST_BAD_TIMER;
            end
         end
         mgtu_pkg::OP_CHECK: begin
            if (timer_ok) begin
               do_clear           = 1'b1;
               result.timer_fired = |(fired_ff & timer_hit);
            end else begin
               result.status = mgtu_pkg::ST_BAD_TIMER;
            end
         end
         mgtu_pkg::OP_DRIVE: begin
            pin_wr          = 1'b1;
            result.tx_valid = 1'b1;
            result.tx_byte  = mgtu_pkg::TX_DRIVE_BASE
                            | (item.pin_level ? mgtu_pkg::TX_LEVEL_BIT : '0)
                            | mgtu_pkg::MSG_W'(item.pin_number);
         end
         mgtu_pkg::OP_DIRECTION: begin
            result.tx_valid = 1'b1;
            result.tx_byte  = mgtu_pkg::TX_DIR_BASE
                            | (item.output_mode ? mgtu_pkg::TX_LEVEL_BIT : '0)
                            | mgtu_pkg::MSG_W'(item.pin_number);
         end
         mgtu_pkg::OP_END_IRQ: begin
            irq_pending_in  = 1'b0;
            result.tx_valid = 1'b1;
            result.tx_byte  = mgtu_pkg::TX_END_IRQ;
         end
         default: begin
         end
      endcase

      // Pin update; pins beyond the array stay low
      pin_mask    = mgtu_pkg::PINS_W'(1) << pin_num;
      pin_bits_in = pin_bits_ff;
      if (pin_wr && ({1'b0, pin_num} < (mgtu_pkg::PIN_W + 1)'(mgtu_pkg::NUM_PINS))) begin
         pin_bits_in = pin_lvl ? (pin_bits_ff | pin_mask) : (pin_bits_ff & ~pin_mask);
      end

      result.pin_states = pin_bits_in;
      result.irq_active = irq_pending_in;
      result.irq_number = irq_pending_in ? irq_id_in : '0;
   end

   // One counter lane per timer
   for (genvar i = 0; i < NT; i++) begin : g_timer
      logic [mgtu_pkg::TICK_W-1:0] dec;

      assign dec = count_ff[i] - mgtu_pkg::TICK_W'(1);

      always_comb begin
         period_in[i] = period_ff[i];
         count_in[i]  = count_ff[i];
         fired_in[i]  = fired_ff[i];
         // Advance enabled timers; reload and flag on reaching zero
         if (do_tick && (period_ff[i] != '0)) begin
            if (dec == '0) begin
               count_in[i] = period_ff[i];
               fired_in[i] = 1'b1;
            end else begin
               count_in[i] = dec;
            end
         end
         if (do_start && timer_hit[i]) begin
            period_in[i] = ticks;
            count_in[i]  = ticks;
         end
         if (do_clear && timer_hit[i]) begin
            fired_in[i] = 1'b0;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            period_ff[i] <= '0;
            count_ff[i]  <= '0;
            fired_ff[i]  <= 1'b0;
         end else if (commit) begin
            period_ff[i] <= period_in[i];
            count_ff[i]  <= count_in[i];
            fired_ff[i]  <= fired_in[i];
         end
      end
   end

   // Pin and interrupt state
   always_ff @(posedge clock) begin
      if (reset) begin
         pin_bits_ff    <= '0;
         irq_pending_ff <= 1'b0;
         irq_id_ff      <= '0;
      end else if (commit) begin
         pin_bits_ff    <= pin_bits_in;
         irq_pending_ff <= irq_pending_in;
         irq_id_ff      <= irq_id_in;
      end
   end

endmodule

/* design/message_gpio_timer_unit.sv */
// ----------------------------------------------------------------------------
// message_gpio_timer_unit
// Pin, timer and interrupt unit driven by one-byte messages and local
// operations; one result per request.
// ----------------------------------------------------------------------------
//   Channel   Direction   Handshake              Payload
//   req_      in          req_valid/req_ready    opcode, msg_byte, timer_index,
//                                                period_us, pin_number,
//                                                pin_level, output_mode
//   rsp_      out         rsp_valid/rsp_ready    status, tx_valid, tx_byte,
//                                                timer_fired, pin_states,
//                                                irq_active, irq_number
//
// Three register stages: input, period-to-tick product, result. A request
// moves through them in that order to the result register; one request per
// cycle is sustained while each result is taken as it is shown.
// The tick conversion multiplier sets the stage split.
// A held result stalls the whole pipeline; req_ready follows that stall.
// Synchronous reset clears pipeline valids, pins, timers and the interrupt.
// ----------------------------------------------------------------------------
module message_gpio_timer_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [mgtu_pkg::OPCODE_W-1:0]     req_opcode,
   input  logic [mgtu_pkg::MSG_W-1:0]        req_msg_byte,
   input  logic [mgtu_pkg::TIDX_W-1:0]       req_timer_index,
   input  logic [mgtu_pkg::US_W-1:0]         req_period_us,
   input  logic [mgtu_pkg::PIN_W-1:0]        req_pin_number,
   input  logic                              req_pin_level,
   input  logic                              req_output_mode,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [mgtu_pkg::STATUS_W-1:0]     rsp_status,
   output logic                              rsp_tx_valid,
   output logic [mgtu_pkg::MSG_W-1:0]        rsp_tx_byte,
   output logic                              rsp_timer_fired,
   output logic [mgtu_pkg::PINS_W-1:0]       rsp_pin_states,
   output logic                              rsp_irq_active,
   output logic [mgtu_pkg::ARG_W-1:0]        rsp_irq_number
);

   logic                         advance;
   logic                         s1_valid_ff, s2_valid_ff, out_valid_ff;
   mgtu_pkg::req_item_type       req_item, s1_item_ff, s2_item_ff;
   mgtu_pkg::rsp_item_type       result, out_item_ff;
   logic [mgtu_pkg::TICK_W-1:0]  ticks;

   // Move the pipeline whenever the result register is free or drained
   assign advance   = !out_valid_ff || rsp_ready;
   assign req_ready = advance;

   assign req_item.opcode      = req_opcode;
   assign req_item.msg_byte    = req_msg_byte;
   assign req_item.timer_index = req_timer_index;
   assign req_item.period_us   = req_period_us;
   assign req_item.pin_number  = req_pin_number;
   assign req_item.pin_level   = req_pin_level;
   assign req_item.output_mode = req_output_mode;

   // Stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= req_valid;
         s2_valid_ff  <= s1_valid_ff;
         out_valid_ff <= s2_valid_ff;
      end
   end

   // Stage payloads
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_item_ff  <= req_item;
         s2_item_ff  <= s1_item_ff;
         out_item_ff <= result;
      end
   end

   mgtu_tick_div u_tick_div (
      .clock     (clock),
      .enable    (advance),
      .period_us (s1_item_ff.period_us),
      .ticks     (ticks)
   );

   mgtu_core u_core (
      .clock  (clock),
      .reset  (reset),
      .commit (advance && s2_valid_ff),
      .item   (s2_item_ff),
      .ticks  (ticks),
      .result (result)
   );

   assign rsp_valid       = out_valid_ff;
   assign rsp_status      = out_item_ff.status;
   assign rsp_tx_valid    = out_item_ff.tx_valid;
   assign rsp_tx_byte     = out_item_ff.tx_byte;
   assign rsp_timer_fired = out_item_ff.timer_fired;
   assign rsp_pin_states  = out_item_ff.pin_states;
   assign rsp_irq_active  = out_item_ff.irq_active;
   assign rsp_irq_number  = out_item_ff.irq_number;

endmodule
